FILE: hw/rtl/edf_mac_tx_scheduler_macros.svh
// Assertion macros used by the transmit scheduler datapath.
`ifndef EDF_MAC_TX_SCHEDULER_MACROS_SVH
`define EDF_MAC_TX_SCHEDULER_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define EDFTX_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define EDFTX_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define EDFTX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/edftx_pkg.sv
// Package: shared types, constants and control structs of the transmit scheduler.
`timescale 1ns / 1ps
package edftx_pkg;

   // Default parameter values
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int GAP_BITS_DEF    = 96;

   // Field widths
   localparam int TAG_W    = 16;
   localparam int DL_W     = 32;
   localparam int BITS_W   = 14;
   localparam int VID_W    = 12;
   localparam int BPT_W    = 16;
   localparam int VCNT_W   = 3;
   localparam int KIND_W   = 2;
   localparam int FILL_W   = 5;
   localparam int REM_W    = 17;
   localparam int NUM_VLAN = 4;

   // Register port
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_BITS_PER_TICK = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_VLAN_COUNT    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_VLAN_A        = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_VLAN_B        = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_VLAN_C        = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_VLAN_D        = 3'd5;

   typedef enum logic [KIND_W-1:0] {
      EV_ACCEPTED  = 2'd0,
      EV_DROP_VLAN = 2'd1,
      EV_DROP_FULL = 2'd2,
      EV_TX_START  = 2'd3
   } event_type;

   // Code 3 is never entered and decodes as idle
   typedef enum logic [1:0] {
      LINE_IDLE = 2'd0,
      LINE_TX   = 2'd1,
      LINE_GAP  = 2'd2
   } line_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [DL_W-1:0]   deadline;
      logic [BITS_W-1:0] frame_bits;
   } entry_type;

   typedef struct packed {
      logic [BPT_W-1:0]                bits_per_tick;
      logic [VCNT_W-1:0]               vlan_count;
      logic [NUM_VLAN-1:0][VID_W-1:0]  allowed_vlan;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic      load_in;
      logic      walk_init;
      logic      rd_walk;
      logic      rd_head;
      logic      walk_shift;
      logic      ins_write;
      logic      pop;
      logic      tick;
      logic      emit;
      event_type emit_kind;
      logic      emit_last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_tick;
      logic vlan_reject;
      logic full;
      logic walk_done;
      logic rd_later;
      logic line_busy;
      logic start_due;
      logic out_free;
   } status_type;

endpackage

FILE: hw/rtl/edftx_ctrl.sv
// Controller: sequences filtering, sorted insertion, transmit start and ticks.
`timescale 1ns / 1ps
module edftx_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  edftx_pkg::status_type  status,
   output edftx_pkg::cmd_type     cmd
);
   import edftx_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_WALK_RD,
      S_WALK_CMP,
      S_ACCEPT,
      S_START
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Only the idle state takes a new transaction
   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.emit_kind = EV_ACCEPTED;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (status.is_tick) begin
               cmd.tick = 1'b1;
               if (status.start_due) begin
                  cmd.rd_head = 1'b1;
                  state_in    = S_START;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (status.vlan_reject) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = EV_DROP_VLAN;
                  cmd.emit_last = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (status.full) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = EV_DROP_FULL;
                  cmd.emit_last = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = S_WALK_RD;
            end
         end
         // Walk from the tail toward the head, reading and then comparing each entry
         S_WALK_RD: begin
            if (status.walk_done) begin
               cmd.ins_write = 1'b1;
               state_in      = S_ACCEPT;
            end else begin
               cmd.rd_walk = 1'b1;
               state_in    = S_WALK_CMP;
            end
         end
         S_WALK_CMP: begin
            if (status.rd_later) begin
               cmd.walk_shift = 1'b1;
               state_in       = S_WALK_RD;
            end else begin
               cmd.ins_write = 1'b1;
               state_in      = S_ACCEPT;
            end
         end
         S_ACCEPT: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EV_ACCEPTED;
               cmd.emit_last = status.line_busy;
               if (status.line_busy) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_head = 1'b1;
                  state_in    = S_START;
               end
            end
         end
         S_START: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EV_TX_START;
               cmd.emit_last = 1'b1;
               cmd.pop       = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/edftx_dp.sv
// Datapath: deadline-sorted circular queue, line timer and result register.
`timescale 1ns / 1ps
module edftx_dp #(
   parameter int QUEUE_DEPTH = edftx_pkg::QUEUE_DEPTH_DEF,
   parameter int GAP_BITS    = edftx_pkg::GAP_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  edftx_pkg::cfg_type                cfg,
   input  edftx_pkg::cmd_type                cmd,
   output edftx_pkg::status_type             status,
   input  logic                              req_func,
   input  logic [edftx_pkg::TAG_W-1:0]       req_frame_tag,
   input  logic [edftx_pkg::DL_W-1:0]        req_deadline,
   input  logic [edftx_pkg::BITS_W-1:0]      req_frame_bits,
   input  logic                              req_has_vlan_tag,
   input  logic [edftx_pkg::VID_W-1:0]       req_vlan_id,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [edftx_pkg::KIND_W-1:0]      rsp_event_kind,
   output logic [edftx_pkg::TAG_W-1:0]       rsp_out_tag,
   output logic [edftx_pkg::DL_W-1:0]        rsp_out_deadline,
   output logic [edftx_pkg::BITS_W-1:0]      rsp_out_bits,
   output logic [edftx_pkg::FILL_W-1:0]      rsp_queue_fill,
   output logic                              rsp_is_last
);
   import edftx_pkg::*;

`include "edf_mac_tx_scheduler_macros.svh"

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = PTR_W + 1;
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);
   localparam logic [REM_W-1:0] GAP_REM  = REM_W'(GAP_BITS);

   // Queue storage, ordered from head_ff onward
   entry_type mem [QUEUE_DEPTH];

   // Latched transaction
   logic              func_ff;
   entry_type         in_entry_ff;
   logic              tagged_ff;
   logic [VID_W-1:0]  vid_ff;

   // Queue and walk state
   logic [CNT_W-1:0]  cnt_ff,   cnt_in;
   logic [PTR_W-1:0]  head_ff,  head_in;
   logic [PTR_W-1:0]  wptr_ff,  wptr_in;
   logic [CNT_W-1:0]  wleft_ff, wleft_in;
   entry_type         rd_data_ff;

   // Line timer
   line_type          line_ff,  line_in;
   logic [REM_W-1:0]  rem_ff,   rem_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] kind_ff;
   entry_type         out_entry_ff;
   logic [FILL_W-1:0] fill_ff;
   logic              last_ff;

   logic [SUM_W-1:0]  tail_sum;
   logic [SUM_W-1:0]  tail_wrap;
   logic [PTR_W-1:0]  tail_idx;
   logic [PTR_W-1:0]  wnext;
   logic [VCNT_W-1:0] vcnt_eff;
   logic              vid_match;
   logic [REM_W-1:0]  bpt_ext;
   logic              rem_above;
   logic              line_busy;

   // VLAN filter against the first vlan_count entries, capped at four
   always_comb begin
      vcnt_eff  = (cfg.vlan_count > VCNT_W'(NUM_VLAN)) ? VCNT_W'(NUM_VLAN) : cfg.vlan_count;
      vid_match = 1'b0;
      for (int i = 0; i < NUM_VLAN; i++) begin
         if ((VCNT_W'(i) < vcnt_eff) && (cfg.allowed_vlan[i] == vid_ff)) begin
            vid_match = 1'b1;
         end
      end
   end

   // Tail index and the slot just above the walk pointer
   always_comb begin
      tail_sum  = {1'b0, head_ff} + SUM_W'(cnt_ff);
      tail_wrap = (tail_sum >= DEPTH_S) ? (tail_sum - DEPTH_S) : tail_sum;
      tail_idx  = tail_wrap[PTR_W-1:0];
      wnext     = (wptr_ff == LAST_IDX) ? '0 : (wptr_ff + 1'b1);
   end

   assign bpt_ext   = REM_W'(cfg.bits_per_tick);
   assign rem_above = (rem_ff > bpt_ext);
   assign line_busy = (line_ff == LINE_TX) || (line_ff == LINE_GAP);

   // Status to the controller
   always_comb begin
      status.is_tick     = func_ff;
      status.vlan_reject = tagged_ff && (vcnt_eff != '0) && !vid_match;
      status.full        = (cnt_ff == FULL_CNT);
      status.walk_done   = (wleft_ff == '0);
      status.rd_later    = (rd_data_ff.deadline > in_entry_ff.deadline);
      status.line_busy   = line_busy;
      status.start_due   = (line_ff == LINE_GAP) && (cfg.bits_per_tick != '0) &&
                           !rem_above && (cnt_ff != '0);
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   // Queue bookkeeping
   always_comb begin
      cnt_in   = cnt_ff;
      head_in  = head_ff;
      wptr_in  = wptr_ff;
      wleft_in = wleft_ff;
      if (cmd.walk_init) begin
         wptr_in  = (tail_idx == '0) ? LAST_IDX : (tail_idx - 1'b1);
         wleft_in = cnt_ff;
      end
      if (cmd.walk_shift) begin
         wptr_in  = (wptr_ff == '0) ? LAST_IDX : (wptr_ff - 1'b1);
         wleft_in = wleft_ff - 1'b1;
      end
      if (cmd.ins_write) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.pop) begin
         cnt_in  = cnt_ff - 1'b1;
         head_in = (head_ff == LAST_IDX) ? '0 : (head_ff + 1'b1);
      end
   end

   // Line timer: transmit countdown, then interframe gap
   always_comb begin
      line_in = line_ff;
      rem_in  = rem_ff;
      if (cmd.tick && (cfg.bits_per_tick != '0)) begin
         case (line_ff)
            LINE_TX: begin
               if (rem_above) begin
                  rem_in = rem_ff - bpt_ext;
               end else begin
                  line_in = LINE_GAP;
                  rem_in  = GAP_REM;
               end
            end
            LINE_GAP: begin
               if (rem_above) begin
                  rem_in = rem_ff - bpt_ext;
               end else if (cnt_ff == '0) begin
                  line_in = LINE_IDLE;
                  rem_in  = '0;
               end
            end
            default: begin
               line_in = line_ff;
            end
         endcase
      end
      if (cmd.pop) begin
         line_in = LINE_TX;
         rem_in  = REM_W'(rd_data_ff.frame_bits);
      end
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         head_ff      <= '0;
         line_ff      <= LINE_IDLE;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         line_ff      <= line_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Transaction latch and walk registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         func_ff                <= req_func;
         in_entry_ff.tag        <= req_frame_tag;
         in_entry_ff.deadline   <= req_deadline;
         in_entry_ff.frame_bits <= req_frame_bits;
         tagged_ff              <= req_has_vlan_tag;
         vid_ff                 <= req_vlan_id;
      end
      wptr_ff  <= wptr_in;
      wleft_ff <= wleft_in;
   end

   // Queue memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.walk_shift) begin
         mem[wnext] <= rd_data_ff;
      end else if (cmd.ins_write) begin
         mem[wnext] <= in_entry_ff;
      end
      if (cmd.rd_walk) begin
         rd_data_ff <= mem[wptr_ff];
      end else if (cmd.rd_head) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         kind_ff      <= cmd.emit_kind;
         out_entry_ff <= (cmd.emit_kind == EV_TX_START) ? rd_data_ff : in_entry_ff;
         fill_ff      <= FILL_W'(cnt_in);
         last_ff      <= cmd.emit_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_out_tag      = out_entry_ff.tag;
   assign rsp_out_deadline = out_entry_ff.deadline;
   assign rsp_out_bits     = out_entry_ff.frame_bits;
   assign rsp_queue_fill   = fill_ff;
   assign rsp_is_last      = last_ff;

   // Checks
   `EDFTX_ASSERT_HOLDS(a_fill_bound, clock, reset, cnt_ff <= FULL_CNT, "queue fill above depth")
   `EDFTX_ASSERT_IMPLIES(a_pop_nonempty, clock, reset, cmd.pop, cnt_ff != '0, "pop from empty queue")
   `EDFTX_ASSERT_IMPLIES(a_insert_room, clock, reset, cmd.ins_write, cnt_ff != FULL_CNT, "insert into full queue")
   `EDFTX_ASSERT_IMPLIES(a_emit_free, clock, reset, cmd.emit, !rsp_valid_ff || !rsp_stall, "result register overwritten")
   `EDFTX_ASSERT_NEXT(a_pop_starts_tx, clock, reset, cmd.pop, (line_ff == LINE_TX) && (rem_ff == REM_W'($past(rd_data_ff.frame_bits))), "transmit start did not load frame length")

endmodule

FILE: hw/rtl/edf_mac_tx_scheduler.sv
// Top level: register port, scheduler controller and datapath.
// Enqueue: a dropped frame is answered from the decision state; an accepted one is placed
//   by a sorted walk that reads and compares each later-deadline frame (single read port),
//   a walk step that meets an earlier entry ends it, and an idle line adds a transmit start.
// Tick: counts down the line, may start a frame. A stalled result holds the controller.
// Reset clears registers to defaults, the line to idle and the queue to empty;
//   queue memory contents are not cleared.
`timescale 1ns / 1ps
module edf_mac_tx_scheduler #(
   parameter int QUEUE_DEPTH = edftx_pkg::QUEUE_DEPTH_DEF,
   parameter int GAP_BITS    = edftx_pkg::GAP_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [edftx_pkg::TAG_W-1:0]       req_frame_tag,
   input  logic [edftx_pkg::DL_W-1:0]        req_deadline,
   input  logic [edftx_pkg::BITS_W-1:0]      req_frame_bits,
   input  logic                              req_has_vlan_tag,
   input  logic [edftx_pkg::VID_W-1:0]       req_vlan_id,
   // Response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [edftx_pkg::KIND_W-1:0]      rsp_event_kind,
   output logic [edftx_pkg::TAG_W-1:0]       rsp_out_tag,
   output logic [edftx_pkg::DL_W-1:0]        rsp_out_deadline,
   output logic [edftx_pkg::BITS_W-1:0]      rsp_out_bits,
   output logic [edftx_pkg::FILL_W-1:0]      rsp_queue_fill,
   output logic                              rsp_is_last,
   // Register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [edftx_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [edftx_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [edftx_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                              csr_pready
);
   import edftx_pkg::*;

   logic [BPT_W-1:0]  bpt_ff,  bpt_in;
   logic [VCNT_W-1:0] vcnt_ff, vcnt_in;
   logic [NUM_VLAN-1:0][VID_W-1:0] vlan_ff, vlan_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic              csr_wr;
   cfg_type           cfg;
   cmd_type           cmd;
   status_type        status;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   // Register write decode
   always_comb begin
      bpt_in  = bpt_ff;
      vcnt_in = vcnt_ff;
      vlan_in = vlan_ff;
      if (csr_wr) begin
         case (reg_idx)
            REG_BITS_PER_TICK: bpt_in     = csr_pwdata[BPT_W-1:0];
            REG_VLAN_COUNT:    vcnt_in    = csr_pwdata[VCNT_W-1:0];
            REG_VLAN_A:        vlan_in[0] = csr_pwdata[VID_W-1:0];
            REG_VLAN_B:        vlan_in[1] = csr_pwdata[VID_W-1:0];
            REG_VLAN_C:        vlan_in[2] = csr_pwdata[VID_W-1:0];
            REG_VLAN_D:        vlan_in[3] = csr_pwdata[VID_W-1:0];
            default:           bpt_in     = bpt_ff;
         endcase
      end
   end

   // Register read mux
   always_comb begin
      case (reg_idx)
         REG_BITS_PER_TICK: csr_prdata = CSR_DW'(bpt_ff);
         REG_VLAN_COUNT:    csr_prdata = CSR_DW'(vcnt_ff);
         REG_VLAN_A:        csr_prdata = CSR_DW'(vlan_ff[0]);
         REG_VLAN_B:        csr_prdata = CSR_DW'(vlan_ff[1]);
         REG_VLAN_C:        csr_prdata = CSR_DW'(vlan_ff[2]);
         REG_VLAN_D:        csr_prdata = CSR_DW'(vlan_ff[3]);
         default:           csr_prdata = '0;
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bpt_ff  <= BPT_W'(1);
         vcnt_ff <= '0;
         vlan_ff <= '0;
      end else begin
         bpt_ff  <= bpt_in;
         vcnt_ff <= vcnt_in;
         vlan_ff <= vlan_in;
      end
   end

   assign cfg.bits_per_tick = bpt_ff;
   assign cfg.vlan_count    = vcnt_ff;
   assign cfg.allowed_vlan  = vlan_ff;

   edftx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   edftx_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .GAP_BITS    (GAP_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_func),
      .req_frame_tag    (req_frame_tag),
      .req_deadline     (req_deadline),
      .req_frame_bits   (req_frame_bits),
      .req_has_vlan_tag (req_has_vlan_tag),
      .req_vlan_id      (req_vlan_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_deadline (rsp_out_deadline),
      .rsp_out_bits     (rsp_out_bits),
      .rsp_queue_fill   (rsp_queue_fill),
      .rsp_is_last      (rsp_is_last)
   );

endmodule

FILE: tb/tb_edf_mac_tx_scheduler.sv
// Testbench for the EDF transmit scheduler: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps
module tb_edf_mac_tx_scheduler;
   import edftx_pkg::*;

   localparam int  QDEPTH        = QUEUE_DEPTH_DEF;
   localparam int  GAP           = GAP_BITS_DEF;
   localparam int  SETTLE_CYCLES = 2 * QDEPTH + 16;
   localparam int  IDLE_LIMIT    = 2000;
   localparam int  MAX_REPORTS   = 10;
   localparam int  RAND_PHASES   = 10;
   localparam int  PHASE_ITEMS   = 100;
   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   typedef struct {
      logic              func;
      logic [TAG_W-1:0]  tag;
      logic [DL_W-1:0]   deadline;
      logic [BITS_W-1:0] frame_bits;
      logic              vlan_tagged;
      logic [VID_W-1:0]  vid;
   } frame_req_type;

   typedef struct {
      event_type         kind;
      logic [TAG_W-1:0]  tag;
      logic [DL_W-1:0]   deadline;
      logic [BITS_W-1:0] frame_bits;
      logic [FILL_W-1:0] fill;
      logic              last;
   } sched_event_type;

   // DUT signals
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_func = 1'b0;
   logic [TAG_W-1:0]    req_frame_tag = '0;
   logic [DL_W-1:0]     req_deadline = '0;
   logic [BITS_W-1:0]   req_frame_bits = '0;
   logic                req_has_vlan_tag = 1'b0;
   logic [VID_W-1:0]    req_vlan_id = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [KIND_W-1:0]   rsp_event_kind;
   logic [TAG_W-1:0]    rsp_out_tag;
   logic [DL_W-1:0]     rsp_out_deadline;
   logic [BITS_W-1:0]   rsp_out_bits;
   logic [FILL_W-1:0]   rsp_queue_fill;
   logic                rsp_is_last;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // Scheduler state as the testbench sees it
   logic [BPT_W-1:0]    m_rate;
   logic [VCNT_W-1:0]   m_vcount;
   logic [VID_W-1:0]    m_vlan [NUM_VLAN];
   line_type            m_line;
   logic [REM_W-1:0]    m_remaining;
   entry_type           m_queue [QDEPTH];
   int                  m_count;

   sched_event_type     pending_events [$];
   sched_event_type     due_event;

   // Run statistics
   int                  mismatches = 0;
   int                  enq_sent = 0;
   int                  tick_sent = 0;
   int                  results_seen = 0;
   int                  kind_seen [4] = '{0, 0, 0, 0};
   int                  idle_cycles = 0;
   int                  stall_left = 0;
   int                  rsp_wait = 0;
   bit                  req_burst = 1'b0;
   bit                  rsp_burst = 1'b0;

   edf_mac_tx_scheduler u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_frame_tag    (req_frame_tag),
      .req_deadline     (req_deadline),
      .req_frame_bits   (req_frame_bits),
      .req_has_vlan_tag (req_has_vlan_tag),
      .req_vlan_id      (req_vlan_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_deadline (rsp_out_deadline),
      .rsp_out_bits     (rsp_out_bits),
      .rsp_queue_fill   (rsp_queue_fill),
      .rsp_is_last      (rsp_is_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic void note_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("MISMATCH %s", what);
   endfunction

   // Allow-list check; counts above four act as four
   function automatic bit vlan_blocked(logic vlan_tagged, logic [VID_W-1:0] vid);
      int n;
      int i;
      n = (m_vcount > 3'd4) ? 4 : int'(m_vcount);
      if (n == 0 || !vlan_tagged)
         return 1'b0;
      for (i = 0; i < n; i++)
         if (m_vlan[i] == vid)
            return 1'b0;
      return 1'b1;
   endfunction

   // Pop the head frame onto the line
   function automatic sched_event_type start_head();
      sched_event_type ev;
      int i;
      ev.kind       = EV_TX_START;
      ev.tag        = m_queue[0].tag;
      ev.deadline   = m_queue[0].deadline;
      ev.frame_bits = m_queue[0].frame_bits;
      ev.last       = 1'b0;
      m_remaining   = REM_W'(m_queue[0].frame_bits);
      for (i = 1; i < m_count; i++)
         m_queue[i-1] = m_queue[i];
      m_count--;
      m_line  = LINE_TX;
      ev.fill = FILL_W'(m_count);
      return ev;
   endfunction

   function automatic void count_down();
      if (m_remaining > REM_W'(m_rate))
         m_remaining = m_remaining - REM_W'(m_rate);
      else
         m_remaining = '0;
   endfunction

   // Work out the results of one accepted transaction and queue them
   function automatic void predict_request(frame_req_type r);
      sched_event_type ev [2];
      int n;
      int pos;
      int i;
      n = 0;
      if (r.func == FUNC_ENQUEUE) begin
         ev[0].tag        = r.tag;
         ev[0].deadline   = r.deadline;
         ev[0].frame_bits = r.frame_bits;
         ev[0].last       = 1'b0;
         if (vlan_blocked(r.vlan_tagged, r.vid)) begin
            ev[0].kind = EV_DROP_VLAN;
            ev[0].fill = FILL_W'(m_count);
            n = 1;
         end else if (m_count >= QDEPTH) begin
            ev[0].kind = EV_DROP_FULL;
            ev[0].fill = FILL_W'(m_count);
            n = 1;
         end else begin
            // sorted insert, behind equal deadlines
            pos = 0;
            while (pos < m_count && m_queue[pos].deadline <= r.deadline)
               pos++;
            for (i = m_count; i > pos; i--)
               m_queue[i] = m_queue[i-1];
            m_queue[pos].tag        = r.tag;
            m_queue[pos].deadline   = r.deadline;
            m_queue[pos].frame_bits = r.frame_bits;
            m_count++;
            ev[0].kind = EV_ACCEPTED;
            ev[0].fill = FILL_W'(m_count);
            n = 1;
            if (m_line != LINE_TX && m_line != LINE_GAP) begin
               ev[1] = start_head();
               n = 2;
            end
         end
      end else if (m_rate != '0) begin
         if (m_line == LINE_TX) begin
            count_down();
            if (m_remaining == '0) begin
               m_line      = LINE_GAP;
               m_remaining = REM_W'(GAP);
            end
         end else if (m_line == LINE_GAP) begin
            count_down();
            if (m_remaining == '0) begin
               if (m_count > 0) begin
                  ev[0] = start_head();
                  n = 1;
               end else begin
                  m_line = LINE_IDLE;
               end
            end
         end
      end
      if (n > 0)
         ev[n-1].last = 1'b1;
      for (i = 0; i < n; i++)
         pending_events = {pending_events, ev[i]};
   endfunction

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         kind_seen[rsp_event_kind]++;
         if (pending_events.size() == 0) begin
            note_mismatch($sformatf("unexpected result kind %0d tag %h",
                                    rsp_event_kind, rsp_out_tag));
         end else begin
            due_event = pending_events.pop_front();
            if (rsp_event_kind !== due_event.kind || rsp_out_tag !== due_event.tag ||
                rsp_out_deadline !== due_event.deadline ||
                rsp_out_bits !== due_event.frame_bits ||
                rsp_queue_fill !== due_event.fill || rsp_is_last !== due_event.last)
               note_mismatch($sformatf(
                  "exp kind %0d tag %h dl %h bits %0d fill %0d last %b / got %0d %h %h %0d %0d %b",
                  due_event.kind, due_event.tag, due_event.deadline, due_event.frame_bits,
                  due_event.fill, due_event.last, rsp_event_kind, rsp_out_tag,
                  rsp_out_deadline, rsp_out_bits, rsp_queue_fill, rsp_is_last));
         end
      end
   end

   // Result-side backpressure: a random hold after each result, sometimes unprompted
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if ((rsp_valid && !rsp_stall) ||
                   (stall_left == 0 && $urandom_range(0, 7) == 0)) begin
         rsp_wait = draw_wait(rsp_burst);
         stall_left <= rsp_wait;
         rsp_stall  <= (rsp_wait != 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   // Watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, pending_events.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One transaction on the request channel; valid stays up across back-to-back items
   task automatic send_item(frame_req_type r);
      int gap;
      gap = draw_wait(req_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= r.func;
      req_frame_tag    <= r.tag;
      req_deadline     <= r.deadline;
      req_frame_bits   <= r.frame_bits;
      req_has_vlan_tag <= r.vlan_tagged;
      req_vlan_id      <= r.vid;
      do @(posedge clock); while (req_stall);
      predict_request(r);
      if (r.func == FUNC_TICK)
         tick_sent++;
      else
         enq_sent++;
   endtask

   task automatic send_enqueue(logic [TAG_W-1:0] tag, logic [DL_W-1:0] dl,
                               logic [BITS_W-1:0] fbits, logic vlan_tagged,
                               logic [VID_W-1:0] vid);
      frame_req_type r;
      r = '{FUNC_ENQUEUE, tag, dl, fbits, vlan_tagged, vid};
      send_item(r);
   endtask

   // Tick; the ignored fields carry noise
   task automatic send_ticks(int count);
      frame_req_type r;
      repeat (count) begin
         r = '{FUNC_TICK, TAG_W'($urandom), $urandom, BITS_W'($urandom),
               1'($urandom), VID_W'($urandom)};
         send_item(r);
      end
   endtask

   // Let every expected result arrive and the block settle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write followed by a read-back check
   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] reg_value;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_BITS_PER_TICK: begin
            m_rate    = value[BPT_W-1:0];
            reg_value = CSR_DW'(m_rate);
         end
         REG_VLAN_COUNT: begin
            m_vcount  = value[VCNT_W-1:0];
            reg_value = CSR_DW'(m_vcount);
         end
         default: begin
            m_vlan[idx - REG_VLAN_A] = value[VID_W-1:0];
            reg_value = CSR_DW'(value[VID_W-1:0]);
         end
      endcase
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== reg_value)
         note_mismatch($sformatf("register %0d read %h, expected %h",
                                 idx, csr_prdata, reg_value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_vlan_list(int count, int a, int b, int c, int d);
      csr_write(REG_VLAN_COUNT, count);
      csr_write(REG_VLAN_A, a);
      csr_write(REG_VLAN_B, b);
      csr_write(REG_VLAN_C, c);
      csr_write(REG_VLAN_D, d);
   endtask

   // Extreme fields, equal deadlines, zero-length frame at the reset rate
   task automatic test_transmit_basics();
      send_enqueue(16'hFFFF, 32'hFFFF_FFFF, 14'h3FFF, 1'b0, 12'h000);
      send_enqueue(16'h0000, 32'h0000_0000, 14'h0000, 1'b1, 12'hFFF);
      send_enqueue(16'h0001, 32'h0000_0000, 14'h1555, 1'b0, 12'h000);
      send_enqueue(16'h0002, 32'h8000_0000, 14'h2AAA, 1'b1, 12'h555);
      send_ticks(2);
      wait_quiet();
      csr_write(REG_BITS_PER_TICK, 32'h0000_FFFF);
      send_ticks(9);
      wait_quiet();
   endtask

   // Rate zero freezes the line
   task automatic test_zero_rate();
      csr_write(REG_BITS_PER_TICK, 32'd0);
      send_enqueue(16'h1234, 32'd10, 14'd50, 1'b0, 12'h000);
      send_ticks(3);
      wait_quiet();
      csr_write(REG_BITS_PER_TICK, 32'd96);
      send_ticks(3);
      wait_quiet();
   endtask

   // Allow list: full list, oversized count, single entry, filtering off
   task automatic test_vlan_filter();
      csr_write(REG_BITS_PER_TICK, 32'h0000_FFFF);
      set_vlan_list(4, 12'h000, 12'hFFF, 100, 200);
      send_enqueue(16'h0100, 32'd5, 14'd64, 1'b1, 12'hFFF);
      send_enqueue(16'h0101, 32'd5, 14'd64, 1'b1, 12'd300);
      send_enqueue(16'h0102, 32'd4, 14'd64, 1'b0, 12'd300);
      send_enqueue(16'h0103, 32'd6, 14'd64, 1'b1, 12'h000);
      send_enqueue(16'h0104, 32'd3, 14'd64, 1'b1, 12'd100);
      wait_quiet();
      csr_write(REG_VLAN_COUNT, 7);
      send_enqueue(16'h0105, 32'd1, 14'd8, 1'b1, 12'd200);
      send_enqueue(16'h0106, 32'd1, 14'd8, 1'b1, 12'd201);
      wait_quiet();
      csr_write(REG_VLAN_COUNT, 1);
      send_enqueue(16'h0107, 32'd2, 14'd8, 1'b1, 12'hFFF);
      send_enqueue(16'h0108, 32'd2, 14'd8, 1'b1, 12'h000);
      wait_quiet();
      csr_write(REG_VLAN_COUNT, 0);
      send_enqueue(16'h0109, 32'd9, 14'd8, 1'b1, 12'd301);
      send_ticks(20);
      wait_quiet();
   endtask

   // Overfill the queue behind a long frame, then drain it
   task automatic test_queue_full();
      csr_write(REG_BITS_PER_TICK, 32'd1);
      repeat (QDEPTH + 3)
         send_enqueue(TAG_W'($urandom), $urandom_range(0, 7), 14'h3FFF, 1'b0, 12'h000);
      send_ticks(2);
      wait_quiet();
      csr_write(REG_BITS_PER_TICK, 32'h0000_FFFF);
      send_ticks(2 * QDEPTH + 4);
      wait_quiet();
   endtask

   // Random traffic in phases, each with its own register setting
   task automatic test_random_traffic();
      frame_req_type r;
      int phase;
      int k;
      int tick_pct;
      int pick;
      for (phase = 0; phase < RAND_PHASES; phase++) begin
         wait_quiet();
         case (phase)
            0:       csr_write(REG_BITS_PER_TICK, 1);
            1:       csr_write(REG_BITS_PER_TICK, 65535);
            2:       csr_write(REG_BITS_PER_TICK, GAP);
            default: csr_write(REG_BITS_PER_TICK, ($urandom_range(0, 1) == 0) ?
                                  $urandom_range(1, 200) : $urandom_range(1, 65535));
         endcase
         set_vlan_list($urandom_range(0, 7), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095));
         tick_pct = $urandom_range(25, 75);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 40 == 0) begin
               req_burst = ($urandom_range(0, 3) == 0);
               rsp_burst = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < tick_pct) begin
               send_ticks(1);
            end else begin
               r.func        = FUNC_ENQUEUE;
               r.tag         = TAG_W'($urandom);
               r.vlan_tagged = 1'($urandom);
               // mostly listed ids so frames get through the filter
               r.vid    = ($urandom_range(0, 9) < 7) ? m_vlan[$urandom_range(0, NUM_VLAN-1)]
                                                     : VID_W'($urandom);
               pick = $urandom_range(0, 9);
               if (pick < 3)
                  r.deadline = $urandom_range(0, 3);
               else if (pick == 3)
                  r.deadline = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
               else
                  r.deadline = $urandom;
               pick = $urandom_range(0, 9);
               if (pick < 4)
                  r.frame_bits = BITS_W'($urandom_range(0, 200));
               else if (pick == 4)
                  r.frame_bits = ($urandom_range(0, 1) == 0) ? 14'h0 : 14'h3FFF;
               else
                  r.frame_bits = BITS_W'($urandom);
               send_item(r);
            end
         end
      end
      req_burst = 1'b0;
      rsp_burst = 1'b0;
   endtask

   initial begin
      m_rate      = 16'd1;
      m_vcount    = '0;
      m_vlan      = '{default: '0};
      m_line      = LINE_IDLE;
      m_remaining = '0;
      m_count     = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_transmit_basics();
      test_zero_rate();
      test_vlan_filter();
      test_queue_full();
      test_random_traffic();

      wait_quiet();
      $display("Covered %0d enqueues and %0d ticks, %0d results checked", enq_sent,
               tick_sent, results_seen);
      $display("Events: %0d accepted, %0d VLAN drops, %0d full drops, %0d starts; %0d mismatches",
               kind_seen[EV_ACCEPTED], kind_seen[EV_DROP_VLAN], kind_seen[EV_DROP_FULL],
               kind_seen[EV_TX_START], mismatches);
      if (mismatches == 0 && pending_events.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
